// ===== hw/rtl/ray_box_slab_test_core_macros.svh =====
// assertion helpers shared by the rtl
`ifndef RAY_BOX_SLAB_TEST_CORE_MACROS_SVH
`define RAY_BOX_SLAB_TEST_CORE_MACROS_SVH

// property checked at every clock edge outside reset
`define RBST_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the same cycle as the antecedent
`define RBST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg
// shared types, constants and helper functions of the ray box slab test
// ----------------------------------------------------------------------------
package rbst_pkg;

	localparam int DATA_W        = 32;
	localparam int NUM_W         = 48;   // |face - origin| scaled by 2^16
	localparam int REM_W         = 32;
	localparam int DEF_STEP_BITS = 2;    // quotient bits per divider stage

	typedef logic signed [DATA_W-1:0] q_t;
	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_BOX_LOW_X  = 3'd0;
	localparam reg_idx_t REG_BOX_LOW_Y  = 3'd1;
	localparam reg_idx_t REG_BOX_LOW_Z  = 3'd2;
	localparam reg_idx_t REG_BOX_HIGH_X = 3'd3;
	localparam reg_idx_t REG_BOX_HIGH_Y = 3'd4;
	localparam reg_idx_t REG_BOX_HIGH_Z = 3'd5;

	localparam q_t Q_MAX = 32'sh7fff_ffff;
	localparam q_t Q_MIN = 32'sh8000_0000;

	localparam logic [NUM_W-1:0] Q_POS_LIM = NUM_W'(64'h7fff_ffff);
	localparam logic [NUM_W-1:0] Q_NEG_LIM = NUM_W'(64'h8000_0000);

	// sideband that travels alongside the dividers
	typedef struct packed {
		logic       valid;
		logic       miss;
		logic [2:0] zero;
		logic [5:0] neg;
		q_t         closest;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic             qbit;
	} div_res_t;

	// one restoring division step
	function automatic div_res_t div_step(input logic [REM_W-1:0] rem, input logic nbit,
			input logic [REM_W-1:0] den);
		logic [REM_W:0] t;
		div_res_t r;
		t = {rem, nbit};
		if (t >= {1'b0, den}) begin
			r.rem  = REM_W'(t - {1'b0, den});
			r.qbit = 1'b1;
		end else begin
			r.rem  = t[REM_W-1:0];
			r.qbit = 1'b0;
		end
		return r;
	endfunction

	// signed, saturated distance from magnitude quotient
	function automatic q_t sat_quo(input logic [NUM_W-1:0] q, input logic neg);
		q_t r;
		if (neg) begin
			if (q > Q_NEG_LIM) r = Q_MIN;
			else r = q_t'(32'd0 - q[DATA_W-1:0]);
		end else begin
			if (q > Q_POS_LIM) r = Q_MAX;
			else r = q_t'(q[DATA_W-1:0]);
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/rbst_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rbst_div_pipe
// pipelined unsigned restoring divider, STEP_BITS quotient bits per stage
// ----------------------------------------------------------------------------
module rbst_div_pipe #(
	parameter int STEP_BITS = rbst_pkg::DEF_STEP_BITS
) (
	input  logic                      clk,
	input  logic [rbst_pkg::NUM_W-1:0] num,
	input  logic [rbst_pkg::REM_W-1:0] den,
	output logic [rbst_pkg::NUM_W-1:0] quo
);
	import rbst_pkg::*;

	localparam int STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_W  = STAGES * STEP_BITS;

	logic [PAD_W-1:0] num_s [STAGES];
	logic [PAD_W-1:0] quo_s [STAGES];
	logic [REM_W-1:0] rem_s [STAGES];
	logic [REM_W-1:0] den_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [PAD_W-1:0] num_in, quo_in, num_nx, quo_nx;
		logic [REM_W-1:0] rem_in, den_in, rem_nx;

		if (k == 0) begin : g_first
			assign num_in = PAD_W'(num);
			assign quo_in = '0;
			assign rem_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
		end

		always_comb begin
			div_res_t r;
			rem_nx = rem_in;
			num_nx = num_in;
			quo_nx = quo_in;
			for (int b = 0; b < STEP_BITS; b++) begin
				r      = div_step(rem_nx, num_nx[PAD_W-1], den_in);
				rem_nx = r.rem;
				num_nx = {num_nx[PAD_W-2:0], 1'b0};
				quo_nx = {quo_nx[PAD_W-2:0], r.qbit};
			end
		end

		always_ff @(posedge clk) begin
			num_s[k] <= num_nx;
			quo_s[k] <= quo_nx;
			rem_s[k] <= rem_nx;
			den_s[k] <= den_in;
		end
	end

	assign quo = quo_s[STAGES-1][NUM_W-1:0];

endmodule

// ===== hw/rtl/rbst_reduce.sv =====
// ----------------------------------------------------------------------------
// rbst_reduce
// saturates face distances, merges the slabs and makes the hit decision
// ----------------------------------------------------------------------------
module rbst_reduce (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [5:0][rbst_pkg::NUM_W-1:0]  quo,
	input  rbst_pkg::side_t                  side,
	output logic                             done,
	output logic                             hit,
	output rbst_pkg::q_t                     closest_after
);
	import rbst_pkg::*;

	q_t   ta_c [3];
	q_t   tb_c [3];
	q_t   ta_s1 [3];
	q_t   tb_s1 [3];
	logic valid_s1, miss_s1;
	q_t   closest_s1;

	q_t   near_c, far_c;
	q_t   near_s2, far_s2, closest_s2;
	logic valid_s2, miss_s2;

	logic valid_s3, hit_s3;
	q_t   closest_s3;

	// per axis entry and exit, zero direction opens the slab
	always_comb begin
		q_t t0, t1;
		for (int a = 0; a < 3; a++) begin
			t0 = sat_quo(quo[a], side.neg[a]);
			t1 = sat_quo(quo[a+3], side.neg[a+3]);
			if (side.zero[a]) begin
				ta_c[a] = Q_MIN;
				tb_c[a] = Q_MAX;
			end else if (t0 < t1) begin
				ta_c[a] = t0;
				tb_c[a] = t1;
			end else begin
				ta_c[a] = t1;
				tb_c[a] = t0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ta_s1      <= ta_c;
		tb_s1      <= tb_c;
		miss_s1    <= side.miss;
		closest_s1 <= side.closest;
	end

	always_comb begin
		near_c = ta_s1[0];
		far_c  = tb_s1[0];
		for (int a = 1; a < 3; a++) begin
			if (ta_s1[a] > near_c) near_c = ta_s1[a];
			if (tb_s1[a] < far_c) far_c = tb_s1[a];
		end
	end

	always_ff @(posedge clk) begin
		near_s2    <= near_c;
		far_s2     <= far_c;
		miss_s2    <= miss_s1;
		closest_s2 <= closest_s1;
	end

	always_ff @(posedge clk) begin
		if (!miss_s2 && (near_s2 < far_s2) && (near_s2 < closest_s2)) begin
			hit_s3     <= 1'b1;
			closest_s3 <= near_s2;
		end else begin
			hit_s3     <= 1'b0;
			closest_s3 <= closest_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= side.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign done          = valid_s3;
	assign hit           = hit_s3;
	assign closest_after = closest_s3;

endmodule

// ===== hw/rtl/ray_box_slab_test_core.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// ray versus axis-aligned box slab test in signed q16.16, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   box corners are written through cfg_we / cfg_index / cfg_wdata, one
//   register per cycle, only while no ray is in flight
//   a ray transfer happens on a clock edge with start high and busy low;
//   busy stays low, so a new ray may be sent on every cycle
//   each ray gives one result: done is high for one cycle with hit and
//   closest_after; the receiver must take it in that cycle
// timing
//   latency is 4 + ceil(48 / STEP_BITS) cycles from start to done
//   (28 cycles with the default of two quotient bits per stage)
//   throughput is one ray per cycle; six pipelined dividers, one per face
//   distance, set the depth of the pipeline
// reset
//   arst_n clears the box to zero and drops every in-flight ray
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_core_macros.svh"

module ray_box_slab_test_core #(
	parameter int STEP_BITS = rbst_pkg::DEF_STEP_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	// ray channel
	input  logic               start,
	output logic               busy,
	input  rbst_pkg::q_t       origin_x,
	input  rbst_pkg::q_t       origin_y,
	input  rbst_pkg::q_t       origin_z,
	input  rbst_pkg::q_t       direction_x,
	input  rbst_pkg::q_t       direction_y,
	input  rbst_pkg::q_t       direction_z,
	input  rbst_pkg::q_t       closest_so_far,
	// result channel
	output logic               done,
	output logic               hit,
	output rbst_pkg::q_t       closest_after,
	// configuration write port
	input  logic               cfg_we,
	input  rbst_pkg::reg_idx_t cfg_index,
	input  rbst_pkg::q_t       cfg_wdata
);
	import rbst_pkg::*;

	localparam int DIV_STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;
	localparam int LATENCY    = DIV_STAGES + 4;

	// box corners
	q_t box_lo_q [3];
	q_t box_hi_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				box_lo_q[a] <= '0;
				box_hi_q[a] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_LOW_X:  box_lo_q[0] <= cfg_wdata;
				REG_BOX_LOW_Y:  box_lo_q[1] <= cfg_wdata;
				REG_BOX_LOW_Z:  box_lo_q[2] <= cfg_wdata;
				REG_BOX_HIGH_X: box_hi_q[0] <= cfg_wdata;
				REG_BOX_HIGH_Y: box_hi_q[1] <= cfg_wdata;
				REG_BOX_HIGH_Z: box_hi_q[2] <= cfg_wdata;
				default: ;   // writes beyond the register list are dropped
			endcase
		end
	end

	// never holds off a ray
	assign busy = 1'b0;

	// stage 1: face minus origin, magnitudes and signs for the dividers
	q_t                 org [3];
	q_t                 dir [3];
	logic [NUM_W-1:0]   num_c  [6];
	logic [REM_W-1:0]   den_c  [3];
	side_t              side_c;

	assign org = '{origin_x, origin_y, origin_z};
	assign dir = '{direction_x, direction_y, direction_z};

	always_comb begin
		logic signed [DATA_W:0] diff;
		logic [DATA_W-1:0]      mag;
		q_t                     face, mn, mx;
		side_c         = '0;
		side_c.valid   = start;
		side_c.closest = closest_so_far;
		for (int f = 0; f < 6; f++) begin
			face = (f < 3) ? box_lo_q[f % 3] : box_hi_q[f % 3];
			// exact 33-bit difference, its magnitude fits 32 bits
			diff = {face[DATA_W-1], face} - {org[f % 3][DATA_W-1], org[f % 3]};
			mag  = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
			num_c[f]      = {mag, 16'b0};
			side_c.neg[f] = diff[DATA_W] ^ dir[f % 3][DATA_W-1];
		end
		for (int a = 0; a < 3; a++) begin
			den_c[a] = dir[a][DATA_W-1] ? REM_W'(-dir[a]) : REM_W'(dir[a]);
			side_c.zero[a] = (dir[a] == '0);
			mn = (box_lo_q[a] < box_hi_q[a]) ? box_lo_q[a] : box_hi_q[a];
			mx = (box_lo_q[a] < box_hi_q[a]) ? box_hi_q[a] : box_lo_q[a];
			// parallel ray outside its slab never enters the box
			if (side_c.zero[a] && ((org[a] < mn) || (org[a] > mx)))
				side_c.miss = 1'b1;
		end
	end

	logic [NUM_W-1:0] num_s1 [6];
	logic [REM_W-1:0] den_s1 [3];
	side_t            side_s1;

	always_ff @(posedge clk) begin
		num_s1 <= num_c;
		den_s1 <= den_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s1 <= '0;
		else side_s1 <= side_c;
	end

	// face distance dividers: low faces x y z, then high faces x y z
	logic [5:0][NUM_W-1:0] quo;

	for (genvar f = 0; f < 6; f++) begin : g_div
		rbst_div_pipe #(
			.STEP_BITS(STEP_BITS)
		) u_div (
			.clk(clk),
			.num(num_s1[f]),
			.den(den_s1[f % 3]),
			.quo(quo[f])
		);
	end

	// sideband delay matching the divider depth
	side_t side_dly_s [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) side_dly_s[k] <= '0;
		end else begin
			side_dly_s[0] <= side_s1;
			for (int k = 1; k < DIV_STAGES; k++) side_dly_s[k] <= side_dly_s[k-1];
		end
	end

	// saturation, slab merge and hit decision
	rbst_reduce u_reduce (
		.clk(clk),
		.arst_n(arst_n),
		.quo(quo),
		.side(side_dly_s[DIV_STAGES-1]),
		.done(done),
		.hit(hit),
		.closest_after(closest_after)
	);

	`RBST_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy, "busy raised")
	`RBST_ASSERT_IMPL(a_done_from_start, clk, arst_n, done, $past(start, LATENCY), "done without ray")
	`RBST_ASSERT_IMPL(a_hit_below_max, clk, arst_n, done && hit, closest_after != Q_MAX, "hit at max")

endmodule
